### rtl/arithmetic_encoder_underflow_macros.svh
// Assertion macros shared by the arithmetic encoder modules.
// Expects clk and arst_n in scope at the point of use.
`ifndef ARITHMETIC_ENCODER_UNDERFLOW_MACROS_SVH
`define ARITHMETIC_ENCODER_UNDERFLOW_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AEU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define AEU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/aeu_pkg.sv
// Shared types, constants and helpers for the arithmetic encoder.
// No dependencies.
package aeu_pkg;

	localparam int SCALE_BITS = 18;
	localparam int FIELD_W    = 18;
	localparam int BOUND_W    = 32;
	localparam int RANGE_W    = BOUND_W + 1;
	localparam int QUO_W      = RANGE_W;
	localparam int DIVD_W     = RANGE_W + SCALE_BITS;
	localparam int MAX_STEPS  = 32;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
	localparam int CQ_DEPTH   = 2;
	localparam int CQ_AW      = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH   = 4;
	localparam int RQ_AW      = $clog2(RQ_DEPTH);

	localparam logic [BOUND_W-1:0] TOP_BIT    = 32'h8000_0000;
	localparam logic [BOUND_W-1:0] SECOND_BIT = 32'h4000_0000;
	localparam logic [BOUND_W-1:0] LOW_KEEP   = 32'h3FFF_FFFF;
	localparam logic [BOUND_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	typedef logic [SCALE_BITS-1:0] cnt_t;
	typedef logic [BOUND_W-1:0]    bound_t;
	typedef logic [RANGE_W-1:0]    range_t;
	typedef logic [QUO_W-1:0]      quo_t;
	typedef logic [DIVD_W-1:0]     divd_t;
	typedef logic [STEP_W-1:0]     step_t;
	typedef logic [DIV_CNT_W-1:0]  div_cnt_t;
	typedef logic [CQ_AW-1:0]      cq_ptr_t;
	typedef logic [CQ_AW:0]        cq_cnt_t;
	typedef logic [RQ_AW-1:0]      rq_ptr_t;
	typedef logic [RQ_AW:0]        rq_cnt_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_ENCODE,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t  op;
		cnt_t lc;
		cnt_t hc;
		cnt_t ts;
	} cmd_t;

	// front -> back command handoff
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef struct packed {
		logic   lead_bit;
		bound_t pending_count;
		logic   last;
	} res_t;

	function automatic bound_t sat_inc(input bound_t v);
		return (v == ALL_ONES) ? v : v + bound_t'(1);
	endfunction

endpackage

### rtl/aeu_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on aeu_pkg. Quotient must fit in QUO_W bits.
module aeu_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  aeu_pkg::divd_t dividend,
	input  aeu_pkg::cnt_t  divisor,
	output logic           done,
	output aeu_pkg::quo_t  quotient
);

	aeu_pkg::cnt_t            rem_q;
	aeu_pkg::quo_t            quo_q;
	aeu_pkg::div_cnt_t        cnt_q;
	logic                     busy_q;
	logic [aeu_pkg::SCALE_BITS:0] trial;
	logic [aeu_pkg::SCALE_BITS:0] diff;
	logic                     ge;

	always_comb begin
		trial = {rem_q, quo_q[aeu_pkg::QUO_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= aeu_pkg::div_cnt_t'(aeu_pkg::QUO_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - aeu_pkg::div_cnt_t'(1);
		end
	end

	// upper dividend bits start as the partial remainder; they stay below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[aeu_pkg::DIVD_W-1:aeu_pkg::QUO_W];
			quo_q <= dividend[aeu_pkg::QUO_W-1:0];
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[aeu_pkg::SCALE_BITS-1:0] : trial[aeu_pkg::SCALE_BITS-1:0];
			quo_q <= {quo_q[aeu_pkg::QUO_W-2:0], ge};
		end
	end

endmodule

### rtl/aeu_front.sv
// Front end: takes input beats, decodes and screens them, queues commands.
// Depends on aeu_pkg and the assertion macro header.
`include "arithmetic_encoder_underflow_macros.svh"

module aeu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   func,
	input  logic [aeu_pkg::FIELD_W-1:0]  sym_low_count,
	input  logic [aeu_pkg::FIELD_W-1:0]  sym_high_count,
	input  logic [aeu_pkg::FIELD_W-1:0]  total_scale,
	output aeu_pkg::cmd_req_t            cmd_req,
	input  logic                         cmd_pop
);

	aeu_pkg::cmd_t    cq_mem_q [aeu_pkg::CQ_DEPTH];
	aeu_pkg::cq_ptr_t wr_ptr_q;
	aeu_pkg::cq_ptr_t rd_ptr_q;
	aeu_pkg::cq_cnt_t cq_cnt_q;
	aeu_pkg::cmd_t    cmd_in;
	logic             keep;
	logic             wr;

	always_comb begin
		cmd_in.op = aeu_pkg::OP_START;
		cmd_in.lc = aeu_pkg::cnt_t'(sym_low_count);
		cmd_in.hc = aeu_pkg::cnt_t'(sym_high_count);
		cmd_in.ts = aeu_pkg::cnt_t'(total_scale);
		keep      = 1'b0;
		unique case (func)
			aeu_pkg::FUNC_START: begin
				cmd_in.op = aeu_pkg::OP_START;
				keep      = 1'b1;
			end
			aeu_pkg::FUNC_ENCODE: begin
				// malformed counts are dropped here
				cmd_in.op = aeu_pkg::OP_ENCODE;
				keep      = (cmd_in.ts != '0) && (cmd_in.lc < cmd_in.hc)
					&& (cmd_in.hc <= cmd_in.ts);
			end
			aeu_pkg::FUNC_FINISH: begin
				cmd_in.op = aeu_pkg::OP_FINISH;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full          = (cq_cnt_q == aeu_pkg::cq_cnt_t'(aeu_pkg::CQ_DEPTH));
	assign wr            = push && !full && keep;
	assign cmd_req.valid = (cq_cnt_q != '0);
	assign cmd_req.cmd   = cq_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + aeu_pkg::cq_ptr_t'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + aeu_pkg::cq_ptr_t'(1);
			end
			case ({wr, cmd_pop})
				2'b10:   cq_cnt_q <= cq_cnt_q + aeu_pkg::cq_cnt_t'(1);
				2'b01:   cq_cnt_q <= cq_cnt_q - aeu_pkg::cq_cnt_t'(1);
				default: cq_cnt_q <= cq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			cq_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	`AEU_ASSERT_IMP(a_cq_bound, 1'b1, cq_cnt_q <= aeu_pkg::cq_cnt_t'(aeu_pkg::CQ_DEPTH), "cmd queue overrun")
	`AEU_ASSERT_IMP(a_cq_pop_nonempty, cmd_pop, cq_cnt_q != '0, "pop from empty cmd queue")
	`AEU_ASSERT_NXT(a_cq_fill, wr && !cmd_pop, cq_cnt_q == $past(cq_cnt_q) + 1'b1, "cmd lost")

endmodule

### rtl/aeu_back.sv
// Back end: interval update with two dividers side by side, renormalization
// sequencer and the result queue. Depends on aeu_pkg, aeu_div, macro header.
`include "arithmetic_encoder_underflow_macros.svh"

module aeu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aeu_pkg::cmd_req_t    cmd_req,
	output logic                 cmd_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 lead_bit,
	output aeu_pkg::bound_t      pending_count,
	output logic                 last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_RENORM
	} state_t;

	state_t           state_q;
	aeu_pkg::bound_t  low_q;
	aeu_pkg::bound_t  high_q;
	aeu_pkg::bound_t  pend_q;
	aeu_pkg::cnt_t    lc_q;
	aeu_pkg::cnt_t    hc_q;
	aeu_pkg::cnt_t    ts_q;
	aeu_pkg::divd_t   prod_h_q;
	aeu_pkg::divd_t   prod_l_q;
	logic             div_start_q;
	aeu_pkg::step_t   steps_q;
	logic             held_q;
	logic             held_bit_q;
	aeu_pkg::bound_t  held_cnt_q;

	aeu_pkg::res_t    rq_mem_q [aeu_pkg::RQ_DEPTH];
	aeu_pkg::rq_ptr_t rq_wr_q;
	aeu_pkg::rq_ptr_t rq_rd_q;
	aeu_pkg::rq_cnt_t rq_cnt_q;

	aeu_pkg::bound_t  diff;
	aeu_pkg::range_t  rng;
	logic             div_h_done;
	logic             div_l_done;
	aeu_pkg::quo_t    qh;
	aeu_pkg::quo_t    ql;
	logic             emit;
	logic             uflow;
	logic             stop;
	logic             rq_space;
	logic             need_push;
	logic             go;
	logic             res_push;
	logic             res_pop;
	aeu_pkg::res_t    res_d;

	aeu_div u_div_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_h_q),
		.divisor  (ts_q),
		.done     (div_h_done),
		.quotient (qh)
	);

	aeu_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_l_q),
		.divisor  (ts_q),
		.done     (div_l_done),
		.quotient (ql)
	);

	always_comb begin
		diff     = high_q - low_q;
		rng      = aeu_pkg::range_t'(diff) + aeu_pkg::range_t'(1);
		emit     = (high_q[aeu_pkg::BOUND_W-1] == low_q[aeu_pkg::BOUND_W-1]);
		uflow    = !emit && low_q[aeu_pkg::BOUND_W-2] && !high_q[aeu_pkg::BOUND_W-2];
		stop     = (steps_q == aeu_pkg::step_t'(aeu_pkg::MAX_STEPS)) || (!emit && !uflow);
		rq_space = (rq_cnt_q != aeu_pkg::rq_cnt_t'(aeu_pkg::RQ_DEPTH));
		// a settled bit is held until the next settled bit or the stop, so its last flag is known when it leaves
		need_push = (state_q == S_RENORM) && held_q && (stop || emit);
		go        = !need_push || rq_space;
		cmd_pop   = (state_q == S_IDLE) && cmd_req.valid
			&& ((cmd_req.cmd.op != aeu_pkg::OP_FINISH) || rq_space);

		res_push = 1'b0;
		res_d.lead_bit      = held_bit_q;
		res_d.pending_count = held_cnt_q;
		res_d.last          = stop;
		if (state_q == S_IDLE) begin
			res_push            = cmd_pop && (cmd_req.cmd.op == aeu_pkg::OP_FINISH);
			res_d.lead_bit      = low_q[aeu_pkg::BOUND_W-2];
			res_d.pending_count = aeu_pkg::sat_inc(pend_q);
			res_d.last          = 1'b1;
		end else begin
			res_push = need_push && rq_space;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= '0;
			high_q      <= aeu_pkg::ALL_ONES;
			pend_q      <= '0;
			lc_q        <= '0;
			hc_q        <= '0;
			ts_q        <= '0;
			prod_h_q    <= '0;
			prod_l_q    <= '0;
			div_start_q <= 1'b0;
			steps_q     <= '0;
			held_q      <= 1'b0;
			held_bit_q  <= 1'b0;
			held_cnt_q  <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd_req.cmd.op)
							aeu_pkg::OP_START: begin
								low_q  <= '0;
								high_q <= aeu_pkg::ALL_ONES;
								pend_q <= '0;
							end
							aeu_pkg::OP_FINISH: begin
								pend_q <= '0;
							end
							aeu_pkg::OP_ENCODE: begin
								lc_q    <= cmd_req.cmd.lc;
								hc_q    <= cmd_req.cmd.hc;
								ts_q    <= cmd_req.cmd.ts;
								state_q <= S_MUL;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_MUL: begin
					prod_h_q    <= aeu_pkg::divd_t'(rng) * aeu_pkg::divd_t'(hc_q);
					prod_l_q    <= aeu_pkg::divd_t'(rng) * aeu_pkg::divd_t'(lc_q);
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_h_done) begin
						high_q  <= low_q + aeu_pkg::bound_t'(qh) - aeu_pkg::bound_t'(1);
						low_q   <= low_q + aeu_pkg::bound_t'(ql);
						steps_q <= '0;
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					if (go) begin
						if (stop) begin
							held_q  <= 1'b0;
							state_q <= S_IDLE;
						end else if (emit) begin
							held_q     <= 1'b1;
							held_bit_q <= high_q[aeu_pkg::BOUND_W-1];
							held_cnt_q <= pend_q;
							pend_q     <= '0;
							low_q      <= {low_q[aeu_pkg::BOUND_W-2:0], 1'b0};
							high_q     <= {high_q[aeu_pkg::BOUND_W-2:0], 1'b1};
							steps_q    <= steps_q + aeu_pkg::step_t'(1);
						end else begin
							pend_q  <= aeu_pkg::sat_inc(pend_q);
							low_q   <= (low_q & aeu_pkg::LOW_KEEP) << 1;
							high_q  <= ((high_q | aeu_pkg::SECOND_BIT) << 1) | aeu_pkg::bound_t'(1);
							steps_q <= steps_q + aeu_pkg::step_t'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result queue
	assign res_pop       = pop && !empty;
	assign empty         = (rq_cnt_q == '0);
	assign lead_bit      = rq_mem_q[rq_rd_q].lead_bit;
	assign pending_count = rq_mem_q[rq_rd_q].pending_count;
	assign last          = rq_mem_q[rq_rd_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				rq_wr_q <= rq_wr_q + aeu_pkg::rq_ptr_t'(1);
			end
			if (res_pop) begin
				rq_rd_q <= rq_rd_q + aeu_pkg::rq_ptr_t'(1);
			end
			case ({res_push, res_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + aeu_pkg::rq_cnt_t'(1);
				2'b01:   rq_cnt_q <= rq_cnt_q - aeu_pkg::rq_cnt_t'(1);
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_mem_q[rq_wr_q] <= res_d;
		end
	end

	`AEU_ASSERT_IMP(a_rq_bound, 1'b1, rq_cnt_q <= aeu_pkg::rq_cnt_t'(aeu_pkg::RQ_DEPTH), "result queue overrun")
	`AEU_ASSERT_IMP(a_div_lockstep, 1'b1, div_h_done == div_l_done, "dividers out of step")
	`AEU_ASSERT_IMP(a_idle_no_held, state_q == S_IDLE, !held_q, "held bit left behind")
	`AEU_ASSERT_IMP(a_step_bound, state_q == S_RENORM, steps_q <= aeu_pkg::step_t'(aeu_pkg::MAX_STEPS), "too many renorm steps")

endmodule

### rtl/arithmetic_encoder_underflow.sv
// Binary arithmetic encoder, 32-bit interval with underflow bit counting.
// Input channel: push/full carries func and the symbol counts; a beat moves
// when push is high and full is low. Start and finish need no divide;
// malformed encode beats and func 3 are dropped at the front with no result.
// Result channel: empty/pop; the oldest result sits on lead_bit,
// pending_count and last while empty is low and moves when pop is high.
// An encode beat runs a multiply, then two 33-step restoring dividers side
// by side on the 51-bit products, then renormalization steps (0 to 32) in
// which the shift sequencer emits one result per settled bit.
// A two-deep command queue lets new beats enter while the back end works;
// a four-deep result queue absorbs results, and when the receiver stalls
// the sequencer holds until space frees up, then the front fills and full rises.
// Reset (arst_n low) empties both queues and sets low 0, high all ones,
// pending count 0. Depends on aeu_pkg, aeu_front, aeu_back, aeu_div.
module arithmetic_encoder_underflow (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   func,
	input  logic [aeu_pkg::FIELD_W-1:0]  sym_low_count,
	input  logic [aeu_pkg::FIELD_W-1:0]  sym_high_count,
	input  logic [aeu_pkg::FIELD_W-1:0]  total_scale,
	output logic                         empty,
	input  logic                         pop,
	output logic                         lead_bit,
	output logic [aeu_pkg::BOUND_W-1:0]  pending_count,
	output logic                         last
);

	aeu_pkg::cmd_req_t cmd_req;
	logic              cmd_pop;

	aeu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.sym_low_count  (sym_low_count),
		.sym_high_count (sym_high_count),
		.total_scale    (total_scale),
		.cmd_req        (cmd_req),
		.cmd_pop        (cmd_pop)
	);

	aeu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_req       (cmd_req),
		.cmd_pop       (cmd_pop),
		.empty         (empty),
		.pop           (pop),
		.lead_bit      (lead_bit),
		.pending_count (pending_count),
		.last          (last)
	);

endmodule
